>>> hw/rtl/node_trs_matrix_compose_core_macros.svh
// Assertion helpers for the transform composer.
`ifndef NODE_TRS_MATRIX_COMPOSE_CORE_MACROS_SVH
`define NODE_TRS_MATRIX_COMPOSE_CORE_MACROS_SVH

// a in this cycle implies b in the same cycle
`define NTMC_ASSERT_IMPLIES(label, clk, rst_n, a, b, msg) \
    label: assert property (@(posedge clk) disable iff (!(rst_n)) (a) |-> (b)) \
        else $error(msg);

// a in this cycle implies b a fixed number of cycles later
`define NTMC_ASSERT_DELAY(label, clk, rst_n, a, n, b, msg) \
    label: assert property (@(posedge clk) disable iff (!(rst_n)) (a) |-> ##n (b)) \
        else $error(msg);

`endif

>>> hw/rtl/ntmc_pkg.sv
package ntmc_pkg;

    localparam int QW   = 16;
    localparam int TW   = 32;
    localparam int PW   = 32;
    localparam int RW   = 34;
    localparam int MW   = RW + QW;
    localparam int OW   = 24;
    localparam int FRAC_SHIFT = 24;
    localparam int LATENCY = 4;

    typedef logic signed [RW-1:0] t_rot_val;
    typedef logic signed [MW-1:0] t_mul_val;

    typedef struct packed {
        logic signed [TW-1:0] trans_x;
        logic signed [TW-1:0] trans_y;
        logic signed [TW-1:0] trans_z;
        logic signed [QW-1:0] quat_x;
        logic signed [QW-1:0] quat_y;
        logic signed [QW-1:0] quat_z;
        logic signed [QW-1:0] quat_w;
        logic                 has_rotation;
        logic signed [QW-1:0] scale_x;
        logic signed [QW-1:0] scale_y;
        logic signed [QW-1:0] scale_z;
    } t_in_item;

    typedef struct packed {
        logic signed [OW-1:0] m00;
        logic signed [OW-1:0] m01;
        logic signed [OW-1:0] m02;
        logic signed [OW-1:0] m10;
        logic signed [OW-1:0] m11;
        logic signed [OW-1:0] m12;
        logic signed [OW-1:0] m20;
        logic signed [OW-1:0] m21;
        logic signed [OW-1:0] m22;
        logic signed [TW-1:0] out_tx;
        logic signed [TW-1:0] out_ty;
        logic signed [TW-1:0] out_tz;
    } t_out_item;

    typedef struct packed {
        logic signed [TW-1:0] tx;
        logic signed [TW-1:0] ty;
        logic signed [TW-1:0] tz;
    } t_trans;

    // quaternion products
    typedef struct packed {
        logic signed [PW-1:0] xx;
        logic signed [PW-1:0] yy;
        logic signed [PW-1:0] zz;
        logic signed [PW-1:0] xy;
        logic signed [PW-1:0] xz;
        logic signed [PW-1:0] yz;
        logic signed [PW-1:0] wx;
        logic signed [PW-1:0] wy;
        logic signed [PW-1:0] wz;
        logic                 has_rot;
        logic signed [QW-1:0] sx;
        logic signed [QW-1:0] sy;
        logic signed [QW-1:0] sz;
        t_trans               trans;
    } t_prod_stage;

    // rotation matrix, column-major: index = col*3 + row
    typedef struct packed {
        t_rot_val [8:0]       r;
        logic signed [QW-1:0] sx;
        logic signed [QW-1:0] sy;
        logic signed [QW-1:0] sz;
        t_trans               trans;
    } t_rot_stage;

    typedef struct packed {
        t_mul_val [8:0] p;
        t_trans         trans;
    } t_mul_stage;

endpackage

>>> hw/rtl/ntmc_quat_mul.sv
module ntmc_quat_mul (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_valid,
    input  ntmc_pkg::t_in_item    i_item,
    output logic                 o_valid,
    output ntmc_pkg::t_prod_stage o_stage
);
    import ntmc_pkg::*;

    logic        r_valid;
    t_prod_stage r_stage;
    t_prod_stage n_stage;

    always_comb begin
        n_stage.xx      = i_item.quat_x * i_item.quat_x;
        n_stage.yy      = i_item.quat_y * i_item.quat_y;
        n_stage.zz      = i_item.quat_z * i_item.quat_z;
        n_stage.xy      = i_item.quat_x * i_item.quat_y;
        n_stage.xz      = i_item.quat_x * i_item.quat_z;
        n_stage.yz      = i_item.quat_y * i_item.quat_z;
        n_stage.wx      = i_item.quat_w * i_item.quat_x;
        n_stage.wy      = i_item.quat_w * i_item.quat_y;
        n_stage.wz      = i_item.quat_w * i_item.quat_z;
        n_stage.has_rot = i_item.has_rotation;
        n_stage.sx      = i_item.scale_x;
        n_stage.sy      = i_item.scale_y;
        n_stage.sz      = i_item.scale_z;
        n_stage.trans.tx = i_item.trans_x;
        n_stage.trans.ty = i_item.trans_y;
        n_stage.trans.tz = i_item.trans_z;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else begin
            r_valid <= i_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_valid) begin
            r_stage <= n_stage;
        end
    end

    assign o_valid = r_valid;
    assign o_stage = r_stage;

endmodule

>>> hw/rtl/ntmc_rot_sum.sv
module ntmc_rot_sum (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_valid,
    input  ntmc_pkg::t_prod_stage i_stage,
    output logic                  o_valid,
    output ntmc_pkg::t_rot_stage  o_stage
);
    import ntmc_pkg::*;

    localparam t_rot_val ONE_Q28 = t_rot_val'(1) <<< 28;

    logic       r_valid;
    t_rot_stage r_stage;
    t_rot_stage n_stage;
    t_rot_val   xx, yy, zz, xy, xz, yz, wx, wy, wz;

    always_comb begin
        xx = RW'(i_stage.xx);
        yy = RW'(i_stage.yy);
        zz = RW'(i_stage.zz);
        xy = RW'(i_stage.xy);
        xz = RW'(i_stage.xz);
        yz = RW'(i_stage.yz);
        wx = RW'(i_stage.wx);
        wy = RW'(i_stage.wy);
        wz = RW'(i_stage.wz);
        if (i_stage.has_rot) begin
            n_stage.r[0] = ONE_Q28 - ((yy + zz) <<< 1);
            n_stage.r[1] = (xy + wz) <<< 1;
            n_stage.r[2] = (xz - wy) <<< 1;
            n_stage.r[3] = (xy - wz) <<< 1;
            n_stage.r[4] = ONE_Q28 - ((xx + zz) <<< 1);
            n_stage.r[5] = (yz + wx) <<< 1;
            n_stage.r[6] = (xz + wy) <<< 1;
            n_stage.r[7] = (yz - wx) <<< 1;
            n_stage.r[8] = ONE_Q28 - ((xx + yy) <<< 1);
        end else begin
            n_stage.r    = '0;
            n_stage.r[0] = ONE_Q28;
            n_stage.r[4] = ONE_Q28;
            n_stage.r[8] = ONE_Q28;
        end
        n_stage.sx    = i_stage.sx;
        n_stage.sy    = i_stage.sy;
        n_stage.sz    = i_stage.sz;
        n_stage.trans = i_stage.trans;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else begin
            r_valid <= i_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_valid) begin
            r_stage <= n_stage;
        end
    end

    assign o_valid = r_valid;
    assign o_stage = r_stage;

endmodule

>>> hw/rtl/ntmc_scale_mul.sv
module ntmc_scale_mul (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_valid,
    input  ntmc_pkg::t_rot_stage i_stage,
    output logic                 o_valid,
    output ntmc_pkg::t_mul_stage o_stage
);
    import ntmc_pkg::*;

    logic       r_valid;
    t_mul_stage r_stage;
    t_mul_stage n_stage;
    t_mul_val   s_ext [3];

    always_comb begin
        s_ext[0] = MW'(i_stage.sx);
        s_ext[1] = MW'(i_stage.sy);
        s_ext[2] = MW'(i_stage.sz);
        for (int i = 0; i < 9; i++) begin
            n_stage.p[i] = MW'($signed(i_stage.r[i])) * s_ext[i / 3];
        end
        n_stage.trans = i_stage.trans;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else begin
            r_valid <= i_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_valid) begin
            r_stage <= n_stage;
        end
    end

    assign o_valid = r_valid;
    assign o_stage = r_stage;

endmodule

>>> hw/rtl/ntmc_round_sat.sv
module ntmc_round_sat (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_valid,
    input  ntmc_pkg::t_mul_stage i_stage,
    output logic                 o_valid,
    output ntmc_pkg::t_out_item  o_result
);
    import ntmc_pkg::*;

    localparam int QTW = MW - FRAC_SHIFT;
    localparam t_mul_val HALF_LSB = t_mul_val'(1) <<< (FRAC_SHIFT - 1);
    localparam logic signed [OW-1:0] OUT_MAX = {1'b0, {(OW-1){1'b1}}};
    localparam logic signed [OW-1:0] OUT_MIN = {1'b1, {(OW-1){1'b0}}};

    logic                 r_valid;
    t_out_item            r_result;
    t_out_item            n_result;
    logic signed [OW-1:0] m [9];
    t_mul_val             v;
    logic signed [QTW-1:0] q;

    always_comb begin
        for (int i = 0; i < 9; i++) begin
            v = $signed(i_stage.p[i]) + HALF_LSB;
            q = QTW'(v >>> FRAC_SHIFT);
            if (q[QTW-1:OW-1] == {(QTW-OW+1){1'b0}} ||
                q[QTW-1:OW-1] == {(QTW-OW+1){1'b1}}) begin
                m[i] = q[OW-1:0];
            end else if (q[QTW-1]) begin
                m[i] = OUT_MIN;
            end else begin
                m[i] = OUT_MAX;
            end
        end
        n_result.m00    = m[0];
        n_result.m01    = m[1];
        n_result.m02    = m[2];
        n_result.m10    = m[3];
        n_result.m11    = m[4];
        n_result.m12    = m[5];
        n_result.m20    = m[6];
        n_result.m21    = m[7];
        n_result.m22    = m[8];
        n_result.out_tx = i_stage.trans.tx;
        n_result.out_ty = i_stage.trans.ty;
        n_result.out_tz = i_stage.trans.tz;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else begin
            r_valid <= i_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_valid) begin
            r_result <= n_result;
        end
    end

    assign o_valid  = r_valid;
    assign o_result = r_result;

endmodule

>>> hw/rtl/node_trs_matrix_compose_core.sv
// Scene-node transform composer: translation, quaternion and per-axis scale
// in, affine matrix T*R*S out (nine Q8.16 linear entries, column-major, plus
// the Q16.16 translation column).
//
// Input channel: drive i_item and raise start; a transaction is taken at each
// rising edge with start high and busy low. busy is high only while reset is
// held, so one transaction can be taken every cycle.
//
// Result channel: o_done is high for exactly one cycle with o_result valid.
// o_done rises once a transaction has passed all register stages, in order,
// one result per input. The four register stages are: quaternion products,
// rotation sums, scale multiply, rounding and saturation. The receiver
// cannot stall, so nothing ever backs up; throughput is one transaction per
// cycle.
//
// Reset (synchronous, active low) clears all stage valid bits; transactions
// in flight are dropped and no strobe follows.
`include "node_trs_matrix_compose_core_macros.svh"

module node_trs_matrix_compose_core (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                start,
    output logic                busy,
    input  ntmc_pkg::t_in_item  i_item,
    output logic                o_done,
    output ntmc_pkg::t_out_item o_result
);
    import ntmc_pkg::*;

    logic        accept;
    logic        s1_valid, s2_valid, s3_valid;
    t_prod_stage s1_stage;
    t_rot_stage  s2_stage;
    t_mul_stage  s3_stage;

    assign busy   = ~i_rst_n;
    assign accept = start & ~busy;

    ntmc_quat_mul u_quat_mul (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (accept),
        .i_item  (i_item),
        .o_valid (s1_valid),
        .o_stage (s1_stage)
    );

    ntmc_rot_sum u_rot_sum (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (s1_valid),
        .i_stage (s1_stage),
        .o_valid (s2_valid),
        .o_stage (s2_stage)
    );

    ntmc_scale_mul u_scale_mul (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (s2_valid),
        .i_stage (s2_stage),
        .o_valid (s3_valid),
        .o_stage (s3_stage)
    );

    ntmc_round_sat u_round_sat (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_valid  (s3_valid),
        .i_stage  (s3_stage),
        .o_valid  (o_done),
        .o_result (o_result)
    );

    `NTMC_ASSERT_DELAY(a_latency, i_clk, i_rst_n, accept, 4, o_done, "transaction lost in pipe")
    `NTMC_ASSERT_IMPLIES(a_no_spurious, i_clk, i_rst_n, o_done, $past(accept, LATENCY), "strobe without transaction")
    `NTMC_ASSERT_DELAY(a_identity, i_clk, i_rst_n, accept && !i_item.has_rotation, 4, (o_result.m01 == '0 && o_result.m10 == '0 && o_result.m21 == '0), "identity off-diagonal nonzero")

endmodule
